// ===== rtl/core/rvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_pkg: shared types and encodings for the compressed instruction decoder
// Holds the instruction kind codes, the RVC opcode fields and the result type.
// ----------------------------------------------------------------------------
package rvc_pkg;

  localparam int unsigned InstrWidth = 16;
  localparam int unsigned RegWidth   = 5;
  localparam int unsigned ImmWidth   = 12;

  typedef enum logic [4:0] {
    KIND_NONE   = 5'd0,
    KIND_LW     = 5'd1,
    KIND_SW     = 5'd2,
    KIND_ADDI   = 5'd3,
    KIND_JAL    = 5'd4,
    KIND_LUI    = 5'd5,
    KIND_SRLI   = 5'd6,
    KIND_SRAI   = 5'd7,
    KIND_ANDI   = 5'd8,
    KIND_SUB    = 5'd9,
    KIND_XOR    = 5'd10,
    KIND_OR     = 5'd11,
    KIND_AND    = 5'd12,
    KIND_SLLI   = 5'd13,
    KIND_ADD    = 5'd14,
    KIND_JALR   = 5'd15,
    KIND_EBREAK = 5'd16
  } inst_kind_e;

  // quadrants
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // funct3 codes
  localparam logic [2:0] F3_LW   = 3'd2;
  localparam logic [2:0] F3_SW   = 3'd6;
  localparam logic [2:0] F3_ADDI = 3'd0;
  localparam logic [2:0] F3_JAL  = 3'd1;
  localparam logic [2:0] F3_LUI  = 3'd3;
  localparam logic [2:0] F3_MISC = 3'd4;
  localparam logic [2:0] F3_SLLI = 3'd0;
  localparam logic [2:0] F3_CR   = 3'd4;

  // funct2 of the quadrant 1 misc-alu group
  localparam logic [1:0] F2_SRLI = 2'd0;
  localparam logic [1:0] F2_SRAI = 2'd1;
  localparam logic [1:0] F2_ANDI = 2'd2;
  localparam logic [1:0] F2_CA   = 2'd3;

  // register-register ops of the CA format
  localparam logic [1:0] CA_SUB = 2'd0;
  localparam logic [1:0] CA_XOR = 2'd1;
  localparam logic [1:0] CA_OR  = 2'd2;
  localparam logic [1:0] CA_AND = 2'd3;

  // prime register fields map to x8..x15
  localparam logic [1:0] PRIME_HI = 2'b01;

  localparam logic [RegWidth-1:0] LINK_REG = 5'd1;
  localparam logic [RegWidth-1:0] SP_REG   = 5'd2;

  typedef struct packed {
    inst_kind_e                  inst_kind;
    logic [RegWidth-1:0]         dest_or_src1;
    logic [RegWidth-1:0]         src2;
    logic signed [ImmWidth-1:0]  immediate;
    logic                        unknown;
    logic                        reserved;
  } dec_res_t;

endpackage

// ===== rtl/core/rvc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_if: handshake channels of the compressed instruction decoder
// rvc_in_if carries instruction words, rvc_out_if carries decoded results.
// ----------------------------------------------------------------------------
interface rvc_in_if;
  logic                               valid;
  logic                               ready;
  logic [rvc_pkg::InstrWidth-1:0]     instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

interface rvc_out_if;
  logic                               valid;
  logic                               ready;
  logic [4:0]                         inst_kind;
  logic [rvc_pkg::RegWidth-1:0]       dest_or_src1;
  logic [rvc_pkg::RegWidth-1:0]       src2;
  logic signed [rvc_pkg::ImmWidth-1:0] immediate;
  logic                               unknown;
  logic                               reserved;

  modport source (output valid, output inst_kind, output dest_or_src1, output src2,
                  output immediate, output unknown, output reserved, input ready);
  modport sink   (input valid, input inst_kind, input dest_or_src1, input src2,
                  input immediate, input unknown, input reserved, output ready);
endinterface

// ===== rtl/core/rvc_instruction_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_instruction_decoder: RV32C compressed instruction decoder
// Decodes one 16-bit compressed word into kind, registers, immediate and flags.
// ----------------------------------------------------------------------------
// pipeline: a word passes the input register, then the result register
// throughput: one beat per cycle while the sink takes results; both stages advance
// together then; while a result waits, only an empty input stage takes a word
// reset: rst_ni clears both stage valid bits; payload registers are not reset
module rvc_instruction_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  rvc_in_if.sink            in_i,
  rvc_out_if.source         out_o
);

  logic                               s1_valid_q;
  logic [rvc_pkg::InstrWidth-1:0]     word_q;
  logic                               out_valid_q;
  rvc_pkg::dec_res_t                  res_q;
  rvc_pkg::dec_res_t                  res_d;

  logic s2_take;
  logic in_take;

  assign s2_take   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s2_take;
  assign in_take   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s2_take) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      word_q <= in_i.instr_word;
    end
    if (s2_take && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  // decode
  logic [1:0] quad;
  logic [2:0] f3;
  logic [1:0] f2;
  logic [4:0] rfull1;
  logic [4:0] rfull2;
  logic [4:0] rp1;
  logic [4:0] rp2;
  logic [5:0] imm6;
  logic [11:0] imm_sext;
  logic [11:0] imm_zext;
  logic        unk;

  assign quad     = word_q[1:0];
  assign f3       = word_q[15:13];
  assign f2       = word_q[11:10];
  assign rfull1   = word_q[11:7];
  assign rfull2   = word_q[6:2];
  assign rp1      = {rvc_pkg::PRIME_HI, word_q[9:7]};
  assign rp2      = {rvc_pkg::PRIME_HI, word_q[4:2]};
  assign imm6     = {word_q[12], word_q[6:2]};
  assign imm_sext = {{6{imm6[5]}}, imm6};
  assign imm_zext = {6'd0, imm6};

  always_comb begin
    res_d = '0;
    unk   = 1'b0;
    unique case (quad)
      rvc_pkg::QUAD_0: begin
        if (f3 == rvc_pkg::F3_LW || f3 == rvc_pkg::F3_SW) begin
          res_d.inst_kind    = (f3 == rvc_pkg::F3_LW) ? rvc_pkg::KIND_LW : rvc_pkg::KIND_SW;
          res_d.dest_or_src1 = rp1;
          res_d.src2         = rp2;
          res_d.immediate    = {5'd0, word_q[5], word_q[12:10], word_q[6], 2'd0};
        end else begin
          unk = 1'b1;
        end
      end
      rvc_pkg::QUAD_1: begin
        unique case (f3)
          rvc_pkg::F3_ADDI: begin
            res_d.inst_kind    = rvc_pkg::KIND_ADDI;
            res_d.dest_or_src1 = rfull1;
            res_d.immediate    = imm_sext;
            res_d.reserved     = (rfull1 == '0) || (imm6 == '0);
          end
          rvc_pkg::F3_JAL: begin
            res_d.inst_kind    = rvc_pkg::KIND_JAL;
            res_d.dest_or_src1 = rvc_pkg::LINK_REG;
            res_d.immediate    = {word_q[12], word_q[8], word_q[10:9], word_q[6],
                                  word_q[7], word_q[2], word_q[11], word_q[5:3], 1'b0};
          end
          rvc_pkg::F3_LUI: begin
            res_d.inst_kind    = rvc_pkg::KIND_LUI;
            res_d.dest_or_src1 = rfull1;
            res_d.immediate    = imm_sext;
            res_d.reserved     = (rfull1 == '0) || (rfull1 == rvc_pkg::SP_REG) ||
                                 (imm6 == '0);
          end
          rvc_pkg::F3_MISC: begin
            res_d.dest_or_src1 = rp1;
            unique case (f2)
              rvc_pkg::F2_SRLI, rvc_pkg::F2_SRAI: begin
                res_d.inst_kind = (f2 == rvc_pkg::F2_SRLI) ? rvc_pkg::KIND_SRLI
                                                           : rvc_pkg::KIND_SRAI;
                res_d.immediate = imm_zext;
                res_d.reserved  = (imm6 == '0) || imm6[5];
              end
              rvc_pkg::F2_ANDI: begin
                res_d.inst_kind = rvc_pkg::KIND_ANDI;
                res_d.immediate = imm_sext;
              end
              rvc_pkg::F2_CA: begin
                // bit 12 set is the rv64 word ops, not supported here
                if (!word_q[12]) begin
                  res_d.src2 = rp2;
                  unique case (word_q[6:5])
                    rvc_pkg::CA_SUB: res_d.inst_kind = rvc_pkg::KIND_SUB;
                    rvc_pkg::CA_XOR: res_d.inst_kind = rvc_pkg::KIND_XOR;
                    rvc_pkg::CA_OR:  res_d.inst_kind = rvc_pkg::KIND_OR;
                    rvc_pkg::CA_AND: res_d.inst_kind = rvc_pkg::KIND_AND;
                    default:         res_d.inst_kind = rvc_pkg::KIND_NONE;
                  endcase
                end else begin
                  unk = 1'b1;
                end
              end
              default: unk = 1'b1;
            endcase
          end
          default: unk = 1'b1;
        endcase
      end
      rvc_pkg::QUAD_2: begin
        if (f3 == rvc_pkg::F3_SLLI) begin
          res_d.inst_kind    = rvc_pkg::KIND_SLLI;
          res_d.dest_or_src1 = rfull1;
          res_d.immediate    = imm_zext;
          res_d.reserved     = (imm6 == '0) || imm6[5];
        end else if (f3 == rvc_pkg::F3_CR && word_q[12]) begin
          res_d.dest_or_src1 = rfull1;
          res_d.src2         = rfull2;
          if (rfull2 != '0) begin
            res_d.inst_kind = rvc_pkg::KIND_ADD;
            res_d.reserved  = (rfull1 == '0);
          end else if (rfull1 != '0) begin
            res_d.inst_kind = rvc_pkg::KIND_JALR;
          end else begin
            res_d.inst_kind = rvc_pkg::KIND_EBREAK;
          end
        end else begin
          unk = 1'b1;
        end
      end
      default: unk = 1'b1;
    endcase

    if (unk) begin
      res_d         = '0;
      res_d.unknown = 1'b1;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.inst_kind    = res_q.inst_kind;
  assign out_o.dest_or_src1 = res_q.dest_or_src1;
  assign out_o.src2         = res_q.src2;
  assign out_o.immediate    = res_q.immediate;
  assign out_o.unknown      = res_q.unknown;
  assign out_o.reserved     = res_q.reserved;

  // an accepted word always occupies the input register next cycle
  a_in_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted word lost before the input register");

  // a decoded word moves into the result register when the result side frees up
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_take) |=> out_valid_q)
    else $error("decoded word lost before the result register");

  // unknown encodings carry no kind and no reserved flag
  a_unknown_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.unknown) |->
      (res_q.inst_kind == rvc_pkg::KIND_NONE && !res_q.reserved))
    else $error("unknown result with kind or reserved set");

  // reserved only shows up on kinds that have reserved operand forms
  a_reserved_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.reserved) |->
      (res_q.inst_kind == rvc_pkg::KIND_ADDI || res_q.inst_kind == rvc_pkg::KIND_LUI ||
       res_q.inst_kind == rvc_pkg::KIND_SRLI || res_q.inst_kind == rvc_pkg::KIND_SRAI ||
       res_q.inst_kind == rvc_pkg::KIND_SLLI || res_q.inst_kind == rvc_pkg::KIND_ADD))
    else $error("reserved flag on a kind without reserved forms");

  // loads and stores use prime registers only
  a_prime_regs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.inst_kind == rvc_pkg::KIND_LW ||
                     res_q.inst_kind == rvc_pkg::KIND_SW)) |->
      (res_q.src2[4:3] == rvc_pkg::PRIME_HI && res_q.dest_or_src1[4:3] == rvc_pkg::PRIME_HI))
    else $error("load or store register outside x8..x15");

endmodule

// ===== dv/rvc_decode_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_decode_checker: result predictor and scoreboard for the RVC decoder
// Decodes every accepted instruction word on its own, queues the decoded
// result and compares each result beat field by field with the oldest entry.
// ----------------------------------------------------------------------------
module rvc_decode_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  rvc_in_if           word_i,
  rvc_out_if          res_i,
  output int          errors_o,
  output int          pending_o,
  output int          decoded_o,
  output logic [16:0] kinds_seen_o
);

  rvc_pkg::dec_res_t expected_q[$];
  int                mismatches;
  int                decoded;
  logic [16:0]       kinds_seen;

  function automatic rvc_pkg::dec_res_t decode_rvc(
      input logic [rvc_pkg::InstrWidth-1:0] w);
    rvc_pkg::dec_res_t            r;
    logic [1:0]                   quad;
    logic [2:0]                   f3;
    logic [rvc_pkg::RegWidth-1:0] rd_full;
    logic [rvc_pkg::RegWidth-1:0] rs2_full;
    logic [rvc_pkg::RegWidth-1:0] rd_p;
    logic [rvc_pkg::RegWidth-1:0] rs2_p;
    logic [5:0]                   imm6;
    logic [11:0]                  simm;
    logic                         bad;
    r        = '0;
    bad      = 1'b0;
    quad     = w[1:0];
    f3       = w[15:13];
    rd_full  = w[11:7];
    rs2_full = w[6:2];
    rd_p     = {rvc_pkg::PRIME_HI, w[9:7]};
    rs2_p    = {rvc_pkg::PRIME_HI, w[4:2]};
    imm6     = {w[12], w[6:2]};
    simm     = {{6{imm6[5]}}, imm6};
    if (quad == rvc_pkg::QUAD_0 && (f3 == rvc_pkg::F3_LW || f3 == rvc_pkg::F3_SW)) begin
      r.inst_kind    = (f3 == rvc_pkg::F3_LW) ? rvc_pkg::KIND_LW : rvc_pkg::KIND_SW;
      r.dest_or_src1 = rd_p;
      r.src2         = rs2_p;
      // word offset: uimm[6] = w5, uimm[5:3] = w12:10, uimm[2] = w6
      r.immediate    = {5'd0, w[5], w[12:10], w[6], 2'b00};
    end else if (quad == rvc_pkg::QUAD_1 && f3 == rvc_pkg::F3_ADDI) begin
      r.inst_kind    = rvc_pkg::KIND_ADDI;
      r.dest_or_src1 = rd_full;
      r.immediate    = simm;
      r.reserved     = (rd_full == '0) || (imm6 == '0);
    end else if (quad == rvc_pkg::QUAD_1 && f3 == rvc_pkg::F3_JAL) begin
      r.inst_kind    = rvc_pkg::KIND_JAL;
      r.dest_or_src1 = rvc_pkg::LINK_REG;
      // scrambled CJ offset, bit 11 down to bit 0
      r.immediate    = {w[12], w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
    end else if (quad == rvc_pkg::QUAD_1 && f3 == rvc_pkg::F3_LUI) begin
      r.inst_kind    = rvc_pkg::KIND_LUI;
      r.dest_or_src1 = rd_full;
      r.immediate    = simm;
      r.reserved     = (rd_full == '0) || (rd_full == rvc_pkg::SP_REG) || (imm6 == '0);
    end else if (quad == rvc_pkg::QUAD_1 && f3 == rvc_pkg::F3_MISC) begin
      r.dest_or_src1 = rd_p;
      case (w[11:10])
        rvc_pkg::F2_SRLI, rvc_pkg::F2_SRAI: begin
          r.inst_kind = (w[11:10] == rvc_pkg::F2_SRLI) ? rvc_pkg::KIND_SRLI
                                                       : rvc_pkg::KIND_SRAI;
          r.immediate = {6'd0, imm6};
          r.reserved  = (imm6 == '0) || imm6[5];
        end
        rvc_pkg::F2_ANDI: begin
          r.inst_kind = rvc_pkg::KIND_ANDI;
          r.immediate = simm;
        end
        default: begin
          if (w[12]) begin
            bad = 1'b1;
          end else begin
            r.src2 = rs2_p;
            case (w[6:5])
              rvc_pkg::CA_SUB: r.inst_kind = rvc_pkg::KIND_SUB;
              rvc_pkg::CA_XOR: r.inst_kind = rvc_pkg::KIND_XOR;
              rvc_pkg::CA_OR:  r.inst_kind = rvc_pkg::KIND_OR;
              default:         r.inst_kind = rvc_pkg::KIND_AND;
            endcase
          end
        end
      endcase
    end else if (quad == rvc_pkg::QUAD_2 && f3 == rvc_pkg::F3_SLLI) begin
      r.inst_kind    = rvc_pkg::KIND_SLLI;
      r.dest_or_src1 = rd_full;
      r.immediate    = {6'd0, imm6};
      r.reserved     = (imm6 == '0) || imm6[5];
    end else if (quad == rvc_pkg::QUAD_2 && f3 == rvc_pkg::F3_CR && w[12]) begin
      r.dest_or_src1 = rd_full;
      r.src2         = rs2_full;
      if (rs2_full != '0) begin
        r.inst_kind = rvc_pkg::KIND_ADD;
        r.reserved  = (rd_full == '0);
      end else if (rd_full != '0) begin
        r.inst_kind = rvc_pkg::KIND_JALR;
      end else begin
        r.inst_kind = rvc_pkg::KIND_EBREAK;
      end
    end else begin
      bad = 1'b1;
    end
    if (bad) begin
      r         = '0;
      r.unknown = 1'b1;
    end
    return r;
  endfunction

  task automatic report(input string field, input int want, input int got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rvc_pkg::dec_res_t want;
    if (!rst_ni) begin
      expected_q.delete();
      mismatches   = 0;
      decoded      = 0;
      kinds_seen   = '0;
      errors_o     <= 0;
      pending_o    <= 0;
      decoded_o    <= 0;
      kinds_seen_o <= '0;
    end else begin
      if (word_i.valid && word_i.ready) begin
        expected_q.push_back(decode_rvc(word_i.instr_word));
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: result beat with no word outstanding, kind %0d", $time,
                   res_i.inst_kind);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          decoded++;
          kinds_seen[want.inst_kind] = 1'b1;
          if (res_i.inst_kind !== want.inst_kind)
            report("inst_kind", want.inst_kind, res_i.inst_kind);
          if (res_i.dest_or_src1 !== want.dest_or_src1)
            report("dest_or_src1", want.dest_or_src1, res_i.dest_or_src1);
          if (res_i.src2 !== want.src2)
            report("src2", want.src2, res_i.src2);
          if (res_i.immediate !== want.immediate)
            report("immediate", want.immediate, res_i.immediate);
          if (res_i.unknown !== want.unknown)
            report("unknown", want.unknown, res_i.unknown);
          if (res_i.reserved !== want.reserved)
            report("reserved", want.reserved, res_i.reserved);
        end
      end
      errors_o     <= mismatches;
      pending_o    <= expected_q.size();
      decoded_o    <= decoded;
      kinds_seen_o <= kinds_seen;
    end
  end

endmodule

// ===== dv/rvc_instruction_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_instruction_decoder_tb: top level bench of the RVC decoder
// Drives directed and random compressed words with random gaps and result
// stalls, including one long stall that backs up the pipe; the checker
// scores every result beat.
// ----------------------------------------------------------------------------
module rvc_instruction_decoder_tb;

  localparam int NumRandom  = 1300;
  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int          errors;
  int          pending;
  int          decoded;
  logic [16:0] kinds_seen;
  int          words_taken;
  int          idle_cycles;

  rvc_in_if  in_ch ();
  rvc_out_if out_ch ();

  rvc_instruction_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  rvc_decode_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_i       (in_ch),
    .res_i        (out_ch),
    .errors_o     (errors),
    .pending_o    (pending),
    .decoded_o    (decoded),
    .kinds_seen_o (kinds_seen)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_taken <= 0;
    end else if (in_ch.valid && in_ch.ready) begin
      words_taken <= words_taken + 1;
    end
  end

  // mostly short, now and then long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pack_word(input logic [2:0] f3, input logic b12,
                                            input logic [4:0] hi, input logic [4:0] lo,
                                            input logic [1:0] quad);
    return {f3, b12, hi, lo, quad};
  endfunction

  task automatic send_word(input logic [15:0] w, input bit no_gap);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.instr_word <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // result side: open stretches, random stalls, and one long hold-off
  initial begin
    int  stall_left;
    int  mode_left;
    bit  mode_open;
    bit  hold_done;
    logic nxt;
    stall_left   = 0;
    mode_left    = 0;
    mode_open    = 1'b0;
    hold_done    = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && words_taken >= 400) begin
        hold_done  = 1'b1;
        stall_left = HoldCycles;
      end
      if (mode_left == 0) begin
        mode_open = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(50, 200);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        nxt = 1'b0;
        stall_left--;
      end else if (!mode_open && $urandom_range(0, 3) == 0) begin
        nxt        = 1'b0;
        stall_left = pick_gap();
      end else begin
        nxt = 1'b1;
      end
      out_ch.ready <= nxt;
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout after %0d idle cycles, %0d results outstanding", idle_cycles, pending);
    $display("rvc_instruction_decoder test failed");
    $finish;
  end

  initial begin
    logic [15:0] directed[$];
    logic [2:0]  legal_f3[8];
    logic [1:0]  legal_quad[8];
    logic [15:0] w;
    int          sel;
    legal_quad = '{rvc_pkg::QUAD_0, rvc_pkg::QUAD_0, rvc_pkg::QUAD_1, rvc_pkg::QUAD_1,
                   rvc_pkg::QUAD_1, rvc_pkg::QUAD_1, rvc_pkg::QUAD_2, rvc_pkg::QUAD_2};
    legal_f3   = '{rvc_pkg::F3_LW, rvc_pkg::F3_SW, rvc_pkg::F3_ADDI, rvc_pkg::F3_JAL,
                   rvc_pkg::F3_LUI, rvc_pkg::F3_MISC, rvc_pkg::F3_SLLI, rvc_pkg::F3_CR};
    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.instr_word <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // largest offset
    directed.push_back(pack_word(rvc_pkg::F3_LW, 1'b1, 5'h1F, 5'h1F, rvc_pkg::QUAD_0));
    directed.push_back(pack_word(rvc_pkg::F3_SW, 1'b0, 5'h00, 5'h00, rvc_pkg::QUAD_0));
    // zero rd, zero imm, most negative
    directed.push_back(pack_word(rvc_pkg::F3_ADDI, 1'b0, 5'd0, 5'd1, rvc_pkg::QUAD_1));
    directed.push_back(pack_word(rvc_pkg::F3_ADDI, 1'b0, 5'd5, 5'd0, rvc_pkg::QUAD_1));
    directed.push_back(pack_word(rvc_pkg::F3_ADDI, 1'b1, 5'd31, 5'd0, rvc_pkg::QUAD_1));
    directed.push_back(pack_word(rvc_pkg::F3_JAL, 1'b1, 5'h1F, 5'h1F, rvc_pkg::QUAD_1));
    directed.push_back(pack_word(rvc_pkg::F3_JAL, 1'b0, 5'h1F, 5'h1F, rvc_pkg::QUAD_1));
    // addi16sp space, zero imm
    directed.push_back(pack_word(rvc_pkg::F3_LUI, 1'b0, rvc_pkg::SP_REG, 5'd1,
                                 rvc_pkg::QUAD_1));
    directed.push_back(pack_word(rvc_pkg::F3_LUI, 1'b0, 5'd3, 5'd0, rvc_pkg::QUAD_1));
    directed.push_back(pack_word(rvc_pkg::F3_LUI, 1'b1, 5'd31, 5'h1F, rvc_pkg::QUAD_1));
    // shamt[5], zero shamt
    directed.push_back(pack_word(rvc_pkg::F3_MISC, 1'b1, {rvc_pkg::F2_SRLI, 3'd7}, 5'd1,
                                 rvc_pkg::QUAD_1));
    directed.push_back(pack_word(rvc_pkg::F3_MISC, 1'b0, {rvc_pkg::F2_SRAI, 3'd0}, 5'd0,
                                 rvc_pkg::QUAD_1));
    directed.push_back(pack_word(rvc_pkg::F3_MISC, 1'b0, {rvc_pkg::F2_SRAI, 3'd2}, 5'd31,
                                 rvc_pkg::QUAD_1));
    directed.push_back(pack_word(rvc_pkg::F3_MISC, 1'b1, {rvc_pkg::F2_ANDI, 3'd4}, 5'd0,
                                 rvc_pkg::QUAD_1));
    directed.push_back(pack_word(rvc_pkg::F3_MISC, 1'b0, {rvc_pkg::F2_CA, 3'd0},
                                 {rvc_pkg::CA_SUB, 3'd7}, rvc_pkg::QUAD_1));
    directed.push_back(pack_word(rvc_pkg::F3_MISC, 1'b0, {rvc_pkg::F2_CA, 3'd3},
                                 {rvc_pkg::CA_XOR, 3'd1}, rvc_pkg::QUAD_1));
    directed.push_back(pack_word(rvc_pkg::F3_MISC, 1'b0, {rvc_pkg::F2_CA, 3'd5},
                                 {rvc_pkg::CA_OR, 3'd6}, rvc_pkg::QUAD_1));
    directed.push_back(pack_word(rvc_pkg::F3_MISC, 1'b0, {rvc_pkg::F2_CA, 3'd7},
                                 {rvc_pkg::CA_AND, 3'd0}, rvc_pkg::QUAD_1));
    // subw
    directed.push_back(pack_word(rvc_pkg::F3_MISC, 1'b1, {rvc_pkg::F2_CA, 3'd1},
                                 {rvc_pkg::CA_SUB, 3'd2}, rvc_pkg::QUAD_1));
    directed.push_back(pack_word(rvc_pkg::F3_SLLI, 1'b0, 5'd7, 5'd0, rvc_pkg::QUAD_2));
    directed.push_back(pack_word(rvc_pkg::F3_SLLI, 1'b1, 5'd7, 5'd3, rvc_pkg::QUAD_2));
    // add to x0, jalr, ebreak, jr, mv
    directed.push_back(pack_word(rvc_pkg::F3_CR, 1'b1, 5'd0, 5'd9, rvc_pkg::QUAD_2));
    directed.push_back(pack_word(rvc_pkg::F3_CR, 1'b1, 5'd1, 5'd0, rvc_pkg::QUAD_2));
    directed.push_back(pack_word(rvc_pkg::F3_CR, 1'b1, 5'd0, 5'd0, rvc_pkg::QUAD_2));
    directed.push_back(pack_word(rvc_pkg::F3_CR, 1'b0, 5'd1, 5'd0, rvc_pkg::QUAD_2));
    directed.push_back(pack_word(rvc_pkg::F3_CR, 1'b0, 5'd3, 5'd4, rvc_pkg::QUAD_2));
    directed.push_back(16'hFFFF);
    foreach (directed[i]) send_word(directed[i], 1'b0);

    // mostly legal quadrant/funct3 pairs with random operands, rest raw noise
    for (int i = 0; i < NumRandom; i++) begin
      w = 16'($urandom_range(0, 16'hFFFF));
      if ($urandom_range(0, 3) != 0) begin
        sel      = $urandom_range(0, 7);
        w[1:0]   = legal_quad[sel];
        w[15:13] = legal_f3[sel];
      end
      send_word(w, (i % 128) < 32);
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("decoded %0d words (%0d directed), %0d of 17 kinds seen incl. unsupported",
             decoded, directed.size(), $countones(kinds_seen));
    $display("random gaps and result stalls, one %0d-cycle hold-off with the input backed up",
             HoldCycles);
    if (errors == 0)
      $display("rvc_instruction_decoder test passed");
    else
      $display("rvc_instruction_decoder test failed");
    $finish;
  end

endmodule
